/* sv/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Op and status codes, field widths and the default stack depth.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DefStackDepth = 128;

	typedef enum logic [3:0] {
		OP_PUSH      = 4'd0,
		OP_ADD       = 4'd1,
		OP_SUB       = 4'd2,
		OP_MUL       = 4'd3,
		OP_DIV       = 4'd4,
		OP_MOD       = 4'd5,
		OP_POP_SHOW  = 4'd6,
		OP_PEEK      = 4'd7,
		OP_SWAP      = 4'd8,
		OP_CLEAR     = 4'd9,
		OP_DUP       = 4'd10,
		OP_PUSH_LAST = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_DIV0  = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	// divider request / response
	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [31:0] res;
	} div_rsp_t;

endpackage

/* sv/rpn_div.sv */
// ----------------------------------------------------------------------------
// RPN divider
// Restoring divider, one quotient bit per cycle. Q16.16 divide (a<<16)/b with
// saturation, or integer modulo of the truncated integer parts.
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic             clk,
	input  logic             arst_n,
	input  rpn_pkg::div_req_t req,
	output rpn_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q;   // magnitude of dividend, shifted out msb first
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic        neg_q;   // quotient sign
	logic        rneg_q;  // remainder sign
	logic        mod_q;
	logic        done_q;

	logic signed [31:0] sa, sb;
	logic [47:0] amag;
	logic [31:0] bmag;
	logic [32:0] trial;
	logic [32:0] rem_sh;

	always_comb begin
		sa = req.a;
		sb = req.b;
		if (req.is_mod) begin
			// integer part truncated toward zero: magnitude >> 16
			amag = {32'd0, (sa[31] ? 16'(( ~req.a + 32'd1) >> 16) : req.a[31:16])};
			bmag = {16'd0, (sb[31] ? 16'(( ~req.b + 32'd1) >> 16) : req.b[31:16])};
		end else begin
			amag = {(sa[31] ? (~req.a + 32'd1) : req.a), 16'd0};
			bmag = sb[31] ? (~req.b + 32'd1) : req.b;
		end
		rem_sh = {rem_q[31:0], num_q[47]};
		trial  = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= amag;
			den_q  <= bmag;
			rem_q  <= '0;
			quo_q  <= '0;
			mod_q  <= req.is_mod;
			neg_q  <= req.a[31] ^ req.b[31];
			rneg_q <= req.a[31];
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	logic [31:0] rmag;
	always_comb begin
		rmag = {rem_q[15:0], 16'd0};
		rsp.done = done_q;
		rsp.sat  = 1'b0;
		if (mod_q) begin
			rsp.res = rneg_q ? (~rmag + 32'd1) : rmag;
		end else if (neg_q) begin
			if (quo_q > 48'h8000_0000) begin
				rsp.sat = 1'b1;
				rsp.res = 32'h8000_0000;
			end else begin
				rsp.res = ~quo_q[31:0] + 32'd1;
			end
		end else if (quo_q > 48'h7FFF_FFFF) begin
			rsp.sat = 1'b1;
			rsp.res = 32'h7FFF_FFFF;
		end else begin
			rsp.res = quo_q[31:0];
		end
	end

endmodule

/* sv/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse-Polish stack machine over signed Q16.16 numbers.
// Divide and modulo are computed by the 48-step divider.
// One word at a time: s_tready is low until the result word has been taken.
// arst_n clears the stack pointer, last value and control; stack memory is
// not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rpn_pkg::DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [3:0] op, [35:4] value, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [31:0] shown, [32] show_valid,
	                               // [35:33] status, [43:36] depth, zero fill
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_POPB  = 9'b000000010,
		S_WAITB = 9'b000000100,
		S_POPA  = 9'b000001000,
		S_WAITA = 9'b000010000,
		S_EXEC  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_PUSH  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q;
	logic [PW-1:0] sp_q;
	logic [31:0] last_q;
	rpn_pkg::op_t op_q;
	logic [31:0] val_q;
	logic [31:0] a_q, b_q;
	logic [2:0]  status_q;
	logic [31:0] shown_q;
	logic        showv_q;
	logic [31:0] p1_q, p2_q; // values to push
	logic [1:0]  npush_q;
	logic [63:0] prod_q;
	logic        mul_q;
	rpn_pkg::div_req_t dreq;
	rpn_pkg::div_rsp_t drsp;

	rpn_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {4'd0, 8'(sp_q), status_q, showv_q, shown_q};

	logic [3:0] in_op;
	assign in_op = s_tdata[3:0];

	// shared adder / compare for add, sub, and saturation
	logic [32:0] sum;
	logic        sub_sel;
	always_comb begin
		sub_sel = (op_q == rpn_pkg::OP_SUB);
		sum = {a_q[31], a_q} + (sub_sel ? ~{b_q[31], b_q} + 33'd1 : {b_q[31], b_q});
	end

	// status: first condition recorded wins
	function automatic logic [2:0] fl(input logic [2:0] cur, input rpn_pkg::status_t c);
		fl = (cur == rpn_pkg::ST_OK) ? c : cur;
	endfunction

	logic pops_b, pops_a;
	always_comb begin
		pops_b = (op_q == rpn_pkg::OP_ADD) || (op_q == rpn_pkg::OP_SUB) ||
			(op_q == rpn_pkg::OP_MUL) || (op_q == rpn_pkg::OP_DIV) ||
			(op_q == rpn_pkg::OP_MOD) || (op_q == rpn_pkg::OP_POP_SHOW) ||
			(op_q == rpn_pkg::OP_SWAP) || (op_q == rpn_pkg::OP_DUP);
		pops_a = (op_q == rpn_pkg::OP_ADD) || (op_q == rpn_pkg::OP_SUB) ||
			(op_q == rpn_pkg::OP_MUL) || (op_q == rpn_pkg::OP_DIV) ||
			(op_q == rpn_pkg::OP_MOD) || (op_q == rpn_pkg::OP_SWAP);
	end

	logic b_int_zero;
	assign b_int_zero = b_q[31] ? ((~b_q + 32'd1) < 32'h0001_0000) : (b_q[31:16] == 16'd0);

	always_comb begin
		dreq.start  = 1'b0;
		dreq.is_mod = (op_q == rpn_pkg::OP_MOD);
		dreq.a      = a_q;
		dreq.b      = b_q;
		if (state_q == S_EXEC && !mul_q &&
			(op_q == rpn_pkg::OP_DIV || op_q == rpn_pkg::OP_MOD))
			dreq.start = 1'b1;
	end

	logic signed [63:0] pshift;
	assign pshift = $signed(prod_q) >>> 16;
	logic signed [63:0] mulres;
	always_comb begin
		// truncate toward zero
		if (prod_q[63] && prod_q[15:0] != 16'd0)
			mulres = pshift + 64'sd1;
		else
			mulres = pshift;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_POPB || state_q == S_POPA || state_q == S_IDLE)
			rd_q <= mem[AW'(sp_q - PW'(1))];
		if (state_q == S_PUSH && npush_q != 2'd0 && sp_q < PW'(STACK_DEPTH))
			mem[AW'(sp_q)] <= p1_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC)
			prod_q <= $signed(a_q) * $signed(b_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '0;
			last_q   <= '0;
			status_q <= rpn_pkg::ST_OK;
			showv_q  <= 1'b0;
			shown_q  <= '0;
			npush_q  <= '0;
			mul_q    <= 1'b0;
			op_q     <= rpn_pkg::OP_PUSH;
			val_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
			p1_q     <= '0;
			p2_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= rpn_pkg::op_t'(in_op);
						val_q    <= s_tdata[35:4];
						status_q <= rpn_pkg::ST_OK;
						showv_q  <= 1'b0;
						shown_q  <= '0;
						npush_q  <= '0;
						mul_q    <= 1'b0;
						state_q  <= S_POPB;
					end
				end
				S_POPB: begin
					// rd_q holds top entry (read in IDLE)
					if (pops_b) begin
						if (sp_q == '0) begin
							b_q      <= '0;
							status_q <= fl(status_q, rpn_pkg::ST_EMPTY);
						end else begin
							b_q      <= rd_q;
							sp_q     <= sp_q - PW'(1);
						end
						state_q <= S_WAITB;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_WAITB: begin
					// divide/modulo by zero skips the second pop
					if ((op_q == rpn_pkg::OP_DIV && b_q == '0) ||
						(op_q == rpn_pkg::OP_MOD && b_int_zero)) begin
						status_q <= fl(status_q, rpn_pkg::ST_DIV0);
						state_q  <= S_OUT;
					end else if (pops_a)
						state_q <= S_POPA;
					else
						state_q <= S_EXEC;
				end
				S_POPA: begin
					state_q <= S_WAITA; // rd_q now at new top
				end
				S_WAITA: begin
					if (sp_q == '0) begin
						a_q      <= '0;
						status_q <= fl(status_q, rpn_pkg::ST_EMPTY);
					end else begin
						a_q      <= rd_q;
						sp_q     <= sp_q - PW'(1);
					end
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (op_q)
						rpn_pkg::OP_PUSH: begin
							p1_q <= val_q; npush_q <= 2'd1; state_q <= S_PUSH;
						end
						rpn_pkg::OP_PUSH_LAST: begin
							p1_q <= last_q; npush_q <= 2'd1; state_q <= S_PUSH;
						end
						rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
							if (sum[32] != sum[31]) begin
								status_q <= fl(status_q, rpn_pkg::ST_SAT);
								p1_q <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
							end else
								p1_q <= sum[31:0];
							npush_q <= 2'd1;
							state_q <= S_PUSH;
						end
						rpn_pkg::OP_MUL: begin
							if (!mul_q) begin
								mul_q <= 1'b1; // product registered this cycle
							end else begin
								if (mulres > 64'sh7FFF_FFFF) begin
									status_q <= fl(status_q, rpn_pkg::ST_SAT);
									p1_q <= 32'h7FFF_FFFF;
								end else if (mulres < -64'sh8000_0000) begin
									status_q <= fl(status_q, rpn_pkg::ST_SAT);
									p1_q <= 32'h8000_0000;
								end else
									p1_q <= mulres[31:0];
								npush_q <= 2'd1;
								state_q <= S_PUSH;
							end
						end
						rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_q <= S_DIV;
						rpn_pkg::OP_POP_SHOW: begin
							last_q  <= b_q; shown_q <= b_q; showv_q <= 1'b1;
							state_q <= S_OUT;
						end
						rpn_pkg::OP_PEEK: begin
							showv_q <= 1'b1;
							if (sp_q == '0)
								status_q <= fl(status_q, rpn_pkg::ST_EMPTY);
							else
								shown_q <= rd_q;
							state_q <= S_OUT;
						end
						rpn_pkg::OP_SWAP: begin
							p1_q <= b_q; p2_q <= a_q; npush_q <= 2'd2; state_q <= S_PUSH;
						end
						rpn_pkg::OP_DUP: begin
							p1_q <= b_q; p2_q <= b_q; npush_q <= 2'd2; state_q <= S_PUSH;
						end
						rpn_pkg::OP_CLEAR: begin
							sp_q <= '0; state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_DIV: begin
					if (drsp.done) begin
						if (drsp.sat)
							status_q <= fl(status_q, rpn_pkg::ST_SAT);
						p1_q    <= drsp.res;
						npush_q <= 2'd1;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sp_q < PW'(STACK_DEPTH))
						sp_q <= sp_q + PW'(1);
					else
						status_q <= fl(status_q, rpn_pkg::ST_FULL);
					p1_q    <= p2_q;
					npush_q <= npush_q - 2'd1;
					if (npush_q == 2'd1)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = ^{s_tdata[39:36]};

endmodule

/* sv/rpn_checker.sv */
// ----------------------------------------------------------------------------
// RPN calculator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// never ready for a word while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready with result pending");

	// a result is held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");

	// status code within range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[35:33] <= 3'd4) else $error("bad status");

	// accepted word leaves the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
